>>> design/rqr_pkg.sv
// Package for the thread ready queue: sizes, operation codes and the
// structs passed between the top level and the cell row. No dependencies.
`timescale 1ns / 1ps

package rqr_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 16;
    localparam int OUT_ID_BITS = 16;
    localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    typedef logic [ID_BITS-1:0]    id_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef enum logic [1:0] {
        KIND_ENQUEUE = 2'd0,
        KIND_DEQUEUE = 2'd1,
        KIND_REMOVE  = 2'd2
    } kind_t;

    // operation broadcast to every cell, gated by the accepted request
    typedef struct packed {
        logic enq;
        logic deq;
        logic rem;
        id_t  key;
    } cell_ctrl_t;

    // what a cell tells the top level and its right-hand neighbour
    typedef struct packed {
        logic valid;
        logic hit;    // a match at this cell or nearer the head
        logic first;  // this cell holds the match nearest the head
    } cell_stat_t;

endpackage

>>> design/rqr_cell.sv
// One slot of the ready queue: holds an identifier and its valid bit.
// Depends on rqr_pkg for the control and status structs.
`timescale 1ns / 1ps

module rqr_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  rqr_pkg::cell_ctrl_t ctrl,
    input  logic                prev_valid,
    input  logic                hit_in,
    input  logic                next_valid,
    input  rqr_pkg::id_t        next_id,
    output rqr_pkg::cell_stat_t stat,
    output rqr_pkg::id_t        id
);

    logic         valid_reg;
    logic         valid_next;
    rqr_pkg::id_t id_reg;
    rqr_pkg::id_t id_next;
    logic         match;
    logic         load;
    logic         shift;

    assign match = valid_reg && (id_reg == ctrl.key);
    // first empty slot behind a full one takes the appended identifier
    assign load  = ctrl.enq && !valid_reg && prev_valid;
    // pull from the right on dequeue, or at and behind the removed entry
    assign shift = ctrl.deq || (ctrl.rem && (match || hit_in));

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        if (load)
        begin
            valid_next = 1'b1;
            id_next    = ctrl.key;
        end
        else if (shift)
        begin
            valid_next = next_valid;
            id_next    = next_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign stat.valid = valid_reg;
    assign stat.hit   = hit_in || match;
    assign stat.first = match && !hit_in;
    assign id         = id_reg;

endmodule

>>> design/ready_queue_with_removal.sv
// Top level of the thread ready queue: a row of rqr_cell slots, head at
// cell 0, with the entry count and the registered result.
// Depends on rqr_pkg and rqr_cell.
//
//  channel  | handshake          | fields
//  ---------+--------------------+--------------------------------------
//  request  | start, busy        | kind, thread_id
//  result   | done (strobe)      | found, out_id, rejected, occupancy
//
// Each request is applied to every cell at once and its
// result is strobed on done in the following cycle. The removal search is a
// head-to-tail chain of per-cell compare flags, so the row shifts in the
// same cycle. busy stays low: a request may come every cycle. Reset clears
// the valid bits and the count; stored identifiers need no reset. Results
// cannot be stalled and are shown for exactly one cycle.
`timescale 1ns / 1ps

module ready_queue_with_removal
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  kind,
    input  logic [15:0] thread_id,
    output logic        busy,
    output logic        done,
    output logic        found,
    output logic [15:0] out_id,
    output logic        rejected,
    output logic [4:0]  occupancy
);

    localparam int N = rqr_pkg::QUEUE_DEPTH;

    logic                accept;
    rqr_pkg::cell_ctrl_t ctrl;
    rqr_pkg::cell_stat_t stat [N];
    rqr_pkg::id_t        cell_id [N];
    logic [N-1:0]        valid_vec;
    logic [N:0]          hit_chain;
    rqr_pkg::id_t        rem_id;
    logic                full;
    logic                empty;

    rqr_pkg::count_t count_reg;
    rqr_pkg::count_t count_next;
    logic            done_reg;
    logic            found_reg;
    logic            found_next;
    rqr_pkg::id_t    out_id_reg;
    rqr_pkg::id_t    out_id_next;
    logic            rejected_reg;
    logic            rejected_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == rqr_pkg::count_t'(N));
    assign empty  = (count_reg == '0);

    always_comb
    begin
        ctrl.enq = 1'b0;
        ctrl.deq = 1'b0;
        ctrl.rem = 1'b0;
        ctrl.key = thread_id[rqr_pkg::ID_BITS-1:0];
        if (accept)
        begin
            unique case (rqr_pkg::kind_t'(kind))
                rqr_pkg::KIND_ENQUEUE: ctrl.enq = 1'b1;
                rqr_pkg::KIND_DEQUEUE: ctrl.deq = 1'b1;
                rqr_pkg::KIND_REMOVE:  ctrl.rem = 1'b1;
                default:               ;
            endcase
        end
    end

    assign hit_chain[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            logic         prev_valid;
            logic         next_valid;
            rqr_pkg::id_t next_id;

            if (g == 0)
            begin : g_head
                assign prev_valid = 1'b1;
            end
            else
            begin : g_body
                assign prev_valid = stat[g-1].valid;
            end

            if (g == N - 1)
            begin : g_tail
                assign next_valid = 1'b0;
                assign next_id    = '0;
            end
            else
            begin : g_inner
                assign next_valid = stat[g+1].valid;
                assign next_id    = cell_id[g+1];
            end

            rqr_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .prev_valid (prev_valid),
                .hit_in     (hit_chain[g]),
                .next_valid (next_valid),
                .next_id    (next_id),
                .stat       (stat[g]),
                .id         (cell_id[g])
            );

            assign hit_chain[g+1] = stat[g].hit;
            assign valid_vec[g]   = stat[g].valid;
        end
    endgenerate

    // at most one cell flags first, so an OR picks its identifier
    always_comb
    begin
        rem_id = '0;
        for (int i = 0; i < N; i++)
        begin
            if (stat[i].first)
            begin
                rem_id = rem_id | cell_id[i];
            end
        end
    end

    always_comb
    begin
        count_next    = count_reg;
        found_next    = 1'b0;
        out_id_next   = '0;
        rejected_next = 1'b0;
        if (ctrl.enq)
        begin
            if (full)
            begin
                rejected_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + rqr_pkg::count_t'(1);
            end
        end
        else if (ctrl.deq)
        begin
            if (!empty)
            begin
                found_next  = 1'b1;
                out_id_next = cell_id[0];
                count_next  = count_reg - rqr_pkg::count_t'(1);
            end
        end
        else if (ctrl.rem)
        begin
            if (hit_chain[N])
            begin
                found_next  = 1'b1;
                out_id_next = rem_id;
                count_next  = count_reg - rqr_pkg::count_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg    <= found_next;
        out_id_reg   <= out_id_next;
        rejected_reg <= rejected_next;
    end

    assign done      = done_reg;
    assign found     = found_reg;
    assign out_id    = rqr_pkg::OUT_ID_BITS'(out_id_reg);
    assign rejected  = rejected_reg;
    assign occupancy = 5'(count_reg);

    // count never runs past the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rqr_pkg::count_t'(N))
        else $error("entry count beyond queue depth");

    // valid bits in the row agree with the count
    a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("valid bits disagree with entry count");

    // a result is strobed in the cycle after each request
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("request without result strobe");

    // a refused enqueue never reports an entry taken out and leaves the count at the depth
    a_reject_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rejected) |-> (!found && occupancy == 5'(N)))
        else $error("rejected result inconsistent");

endmodule

>>> test/tb_ready_queue_with_removal.sv
// Testbench for ready_queue_with_removal: directed and random enqueue, dequeue and
// remove-by-identifier requests, each result checked against a queue-based predictor.
// Depends on rqr_pkg and the design files of the ready queue.
`timescale 1ns / 1ps

module tb_ready_queue_with_removal;

    localparam logic [1:0] KIND_NONE = 2'd3;   // unused code: no operation
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_LIMIT = 200;
    localparam int RANDOM_REQUESTS = 1600;

    typedef struct packed {
        logic            found;
        rqr_pkg::id_t    out_id;
        logic            rejected;
        rqr_pkg::count_t occupancy;
    } queue_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic [1:0]  kind;
    logic [15:0] thread_id;
    logic        busy;
    logic        done;
    logic        found;
    logic [15:0] out_id;
    logic        rejected;
    logic [4:0]  occupancy;

    rqr_pkg::id_t  ready_ids[$];        // predicted queue contents, head first
    queue_result_t pending_results[$];  // predicted results not yet strobed
    int            failures = 0;
    int            cycle_count = 0;
    bit            steady_run = 1'b0;

    ready_queue_with_removal DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .kind      (kind),
        .thread_id (thread_id),
        .busy      (busy),
        .done      (done),
        .found     (found),
        .out_id    (out_id),
        .rejected  (rejected),
        .occupancy (occupancy)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= 10)
        begin
            $display("%0t: %s", $time, msg);
        end
    endfunction

    // Apply one request to the predicted queue and return its result.
    function automatic queue_result_t apply_request(input logic [1:0] op,
                                                    input rqr_pkg::id_t id);
        queue_result_t r;
        int            pos;
        r = '0;
        pos = -1;
        case (op)
            rqr_pkg::KIND_ENQUEUE:
            begin
                if (ready_ids.size() < rqr_pkg::QUEUE_DEPTH)
                begin
                    ready_ids.push_back(id);
                end
                else
                begin
                    r.rejected = 1'b1;
                end
            end
            rqr_pkg::KIND_DEQUEUE:
            begin
                if (ready_ids.size() > 0)
                begin
                    r.found = 1'b1;
                    r.out_id = ready_ids.pop_front();
                end
            end
            rqr_pkg::KIND_REMOVE:
            begin
                // search from the head; only the nearest match goes
                for (int i = 0; i < ready_ids.size(); i++)
                begin
                    if (ready_ids[i] == id)
                    begin
                        pos = i;
                        break;
                    end
                end
                if (pos >= 0)
                begin
                    r.found = 1'b1;
                    r.out_id = ready_ids[pos];
                    ready_ids.delete(pos);
                end
            end
            default:
            begin
            end
        endcase
        r.occupancy = rqr_pkg::count_t'(ready_ids.size());
        return r;
    endfunction

    function automatic rqr_pkg::id_t random_id();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3, 4, 5: return rqr_pkg::id_t'($urandom_range(0, 7));
            default: return rqr_pkg::id_t'($urandom());
        endcase
    endfunction

    // Mostly pick an identifier that is held, so removals hit.
    function automatic rqr_pkg::id_t removal_key();
        if (ready_ids.size() > 0 && $urandom_range(0, 3) != 0)
        begin
            return ready_ids[$urandom_range(0, ready_ids.size() - 1)];
        end
        return random_id();
    endfunction

    task automatic send_request(input logic [1:0] op, input rqr_pkg::id_t id);
        int gap;
        int roll;
        start <= 1'b1;
        kind <= op;
        thread_id <= id;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pending_results.push_back(apply_request(op, id));

        if ($urandom_range(0, 39) == 0)
        begin
            steady_run = !steady_run;
        end
        roll = $urandom_range(0, 19);
        if (steady_run || roll < 12)
        begin
            gap = 0;
        end
        else if (roll < 18)
        begin
            gap = $urandom_range(1, 3);
        end
        else
        begin
            gap = $urandom_range(10, 40);
        end
        // hold start high when the next request follows at once
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic test_empty_queue();
        send_request(rqr_pkg::KIND_DEQUEUE, 16'h0000);
        send_request(rqr_pkg::KIND_REMOVE, 16'h0000);
        send_request(KIND_NONE, 16'hFFFF);
    endtask

    task automatic test_fill_and_overflow();
        send_request(rqr_pkg::KIND_ENQUEUE, 16'h0000);
        send_request(rqr_pkg::KIND_ENQUEUE, 16'hFFFF);
        send_request(rqr_pkg::KIND_ENQUEUE, 16'h0005);
        send_request(rqr_pkg::KIND_ENQUEUE, 16'h0005);
        for (int i = 0; i < 12; i++)
        begin
            send_request(rqr_pkg::KIND_ENQUEUE, rqr_pkg::id_t'(16'h0001 << i));
        end
        send_request(rqr_pkg::KIND_ENQUEUE, 16'hAAAA);
    endtask

    task automatic test_remove_cases();
        send_request(rqr_pkg::KIND_REMOVE, 16'h0005);
        send_request(rqr_pkg::KIND_REMOVE, 16'h1234);
        send_request(rqr_pkg::KIND_REMOVE, 16'hFFFF);
        send_request(rqr_pkg::KIND_REMOVE, 16'h0800);
        send_request(KIND_NONE, 16'h0005);
        send_request(rqr_pkg::KIND_DEQUEUE, 16'h0000);
    endtask

    // Fill with random content, at times past full, then take it out by key and by head.
    task automatic test_fill_drain_rounds();
        int fill;
        for (int round = 0; round < 8; round++)
        begin
            fill = $urandom_range(8, 18);
            for (int i = 0; i < fill; i++)
            begin
                send_request(rqr_pkg::KIND_ENQUEUE, random_id());
            end
            while (ready_ids.size() > 0)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    send_request(rqr_pkg::KIND_DEQUEUE, random_id());
                end
                else
                begin
                    send_request(rqr_pkg::KIND_REMOVE, removal_key());
                end
            end
            send_request(rqr_pkg::KIND_DEQUEUE, random_id());
        end
    endtask

    task automatic test_random_traffic();
        int mode;
        int roll;
        int enq_cut;
        int deq_cut;
        mode = 0;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if ($urandom_range(0, 59) == 0)
            begin
                mode = $urandom_range(0, 2);
            end
            // bias towards filling, draining or neither
            case (mode)
                0: begin enq_cut = 40; deq_cut = 65; end
                1: begin enq_cut = 60; deq_cut = 75; end
                default: begin enq_cut = 25; deq_cut = 55; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < enq_cut)
            begin
                send_request(rqr_pkg::KIND_ENQUEUE, random_id());
            end
            else if (roll < deq_cut)
            begin
                send_request(rqr_pkg::KIND_DEQUEUE, random_id());
            end
            else if (roll < 97)
            begin
                send_request(rqr_pkg::KIND_REMOVE, removal_key());
            end
            else
            begin
                send_request(KIND_NONE, random_id());
            end
        end
    endtask

    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                note_failure("result strobed with no request waiting");
            end
            else
            begin
                want = pending_results.pop_front();
                if (found !== want.found || out_id !== want.out_id
                    || rejected !== want.rejected || occupancy !== want.occupancy)
                begin
                    note_failure($sformatf(
                        {"mismatch: expected found=%0b id=%h rej=%0b occ=%0d,",
                         " got found=%0b id=%h rej=%0b occ=%0d"},
                        want.found, want.out_id, want.rejected, want.occupancy,
                        found, out_id, rejected, occupancy));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int waited;
        waited = 0;
        rst_n <= 1'b0;
        start <= 1'b0;
        kind <= rqr_pkg::KIND_ENQUEUE;
        thread_id <= 16'h0000;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_fill_and_overflow();
        test_remove_cases();
        test_fill_drain_rounds();
        test_random_traffic();

        start <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            note_failure($sformatf("%0d results never strobed", pending_results.size()));
        end

        if (failures == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
